// ===== design/mbt_pkg.sv =====
// Shared types, constants and arithmetic helpers for the backprop trainer.
package mbt_pkg;

    localparam int PIPE_DEPTH = 6;

    localparam logic [15:0] OUT_MOM_RST  = 16'd13107;
    localparam logic [15:0] OUT_RATE_RST = 16'd26214;
    localparam logic [15:0] IN_MOM_RST   = 16'd13107;
    localparam logic [15:0] IN_RATE_RST  = 16'd19661;

    localparam logic signed [23:0] MAX24 = 24'sh7FFFFF;
    localparam logic signed [23:0] MIN24 = -24'sh800000;

    typedef enum logic [1:0] {
        OP_TRAIN = 2'd0,
        OP_INFER = 2'd1,
        OP_WRITE = 2'd2,
        OP_READ  = 2'd3
    } op_e_t;

    typedef enum logic [1:0] {
        REG_OUT_MOM  = 2'd0,
        REG_OUT_RATE = 2'd1,
        REG_IN_MOM   = 2'd2,
        REG_IN_RATE  = 2'd3
    } reg_idx_t;

    typedef enum logic [1:0] {
        MODE_FWD,
        MODE_UPD,
        MODE_PASS
    } mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FWD,
        ST_YOUT,
        ST_ERR,
        ST_GAIN,
        ST_UPD,
        ST_PASS,
        ST_OUT
    } state_t;

    // One hidden unit's record as it travels round the ring.
    typedef struct packed {
        logic signed [23:0] w0;
        logic signed [23:0] w1;
        logic signed [23:0] v;
        logic signed [23:0] dw0;
        logic signed [23:0] dw1;
        logic signed [23:0] dv;
        logic        [16:0] act;
    } unit_t;

    typedef struct packed {
        logic [15:0] out_mom;
        logic [15:0] out_rate;
        logic [15:0] in_mom;
        logic [15:0] in_rate;
    } rates_t;

    function automatic logic signed [23:0] sat24(input logic signed [63:0] v);
        logic signed [23:0] r;
        if (v > 64'(MAX24))
            r = MAX24;
        else if (v < 64'(MIN24))
            r = MIN24;
        else
            r = v[23:0];
        return r;
    endfunction

endpackage

// ===== design/mbt_cell.sv =====
// Storage cell of the unit ring: holds one hidden unit and hands it on.
module mbt_cell
    import mbt_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  shift,
    input  unit_t d,
    output unit_t q
);

    unit_t unit_reg;
    unit_t unit_next;

    always_comb
    begin
        unit_next = shift ? d : unit_reg;
    end

    // Momenta, activation and weights all start at zero; weights are then set by writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            unit_reg <= '0;
        else
            unit_reg <= unit_next;
    end

    assign q = unit_reg;

endmodule

// ===== design/mbt_pipe.sv =====
// Processing stages of the ring: forward products, sigmoid, and weight updates.
module mbt_pipe
    import mbt_pkg::*;
#(
    parameter int SIGMOID_ENTRIES = 256
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                shift,
    input  mode_t               mode,
    input  logic                vld_in,
    input  unit_t               rec_in,
    input  logic signed [23:0]  x0,
    input  logic signed [23:0]  x1,
    input  logic signed [23:0]  err,
    input  logic signed [23:0]  gain,
    input  rates_t              rates,
    output unit_t               rec_out,
    output logic                prod_vld,
    output logic signed [41:0]  prod
);

    localparam int IW = (SIGMOID_ENTRIES > 1) ? $clog2(SIGMOID_ENTRIES) : 1;
    localparam int PW = 21 + IW;

    logic [16:0] sig_rom [SIGMOID_ENTRIES];

    // Sigmoid at the centre of each cell: e^-|c| from a Taylor series of e^-(|c|/16)
    // in Q30, squared four times, then a rounded quotient.
    genvar gi;
    generate
        for (gi = 0; gi < SIGMOID_ENTRIES; gi++)
        begin : g_rom
            localparam longint CTR =
                (longint'(2 * gi + 1) * 524288) / SIGMOID_ENTRIES - 524288;
            localparam longint XA  = (CTR < 0) ? -CTR : CTR;
            localparam longint YA  = XA <<< 10;
            localparam longint T0  = longint'(1) <<< 30;
            localparam longint T1  = (T0 * YA) >>> 30;
            localparam longint T2  = ((T1 * YA) >>> 30) / 2;
            localparam longint T3  = ((T2 * YA) >>> 30) / 3;
            localparam longint T4  = ((T3 * YA) >>> 30) / 4;
            localparam longint T5  = ((T4 * YA) >>> 30) / 5;
            localparam longint T6  = ((T5 * YA) >>> 30) / 6;
            localparam longint T7  = ((T6 * YA) >>> 30) / 7;
            localparam longint T8  = ((T7 * YA) >>> 30) / 8;
            localparam longint T9  = ((T8 * YA) >>> 30) / 9;
            localparam longint T10 = ((T9 * YA) >>> 30) / 10;
            localparam longint T11 = ((T10 * YA) >>> 30) / 11;
            localparam longint T12 = ((T11 * YA) >>> 30) / 12;
            localparam longint SUM = T0 - T1 + T2 - T3 + T4 - T5 + T6
                                     - T7 + T8 - T9 + T10 - T11 + T12;
            localparam longint E1  = (SUM * SUM) >>> 30;
            localparam longint E2  = (E1 * E1) >>> 30;
            localparam longint E3  = (E2 * E2) >>> 30;
            localparam longint E4  = (E3 * E3) >>> 30;
            localparam longint DEN = T0 + E4;
            localparam longint QV  = (CTR >= 0) ?
                                     (((longint'(1) <<< 46) + DEN / 2) / DEN) :
                                     (((E4 <<< 16) + DEN / 2) / DEN);
            assign sig_rom[gi] = 17'(QV);
        end
    endgenerate

    // stage A
    unit_t              a_rec;
    logic               a_vld;
    logic signed [47:0] a_p0, a_p1, a_pt;
    logic signed [40:0] a_pdv, a_pw0, a_pw1;
    logic signed [41:0] a_pga;
    logic        [33:0] a_pder;
    // stage B
    unit_t              b_rec;
    logic               b_vld;
    logic signed [23:0] b_s, b_t, b_dv;
    logic        [14:0] b_der;
    logic signed [24:0] b_mw0, b_mw1;
    // stage C
    unit_t              c_rec;
    logic               c_vld;
    logic        [16:0] c_act;
    logic signed [39:0] c_ptd;
    logic signed [23:0] c_v, c_dv;
    logic signed [24:0] c_mw0, c_mw1;
    // stage D
    unit_t              d_rec;
    logic               d_vld;
    logic signed [41:0] d_pva;
    logic signed [40:0] d_pr;
    logic        [16:0] d_act;
    logic signed [23:0] d_v, d_dv;
    logic signed [24:0] d_mw0, d_mw1;
    // stage E
    unit_t              e_rec;
    logic signed [48:0] e_pr0, e_pr1;
    logic        [16:0] e_act;
    logic signed [23:0] e_v, e_dv;
    logic signed [24:0] e_mw0, e_mw1;
    // stage F
    unit_t              f_rec;

    logic [19:0]        sig_u;
    logic [PW-1:0]      sig_p;
    logic [IW-1:0]      sig_idx;
    logic signed [24:0] r_val;
    logic signed [23:0] dw0_new, dw1_new;
    unit_t              f_next;

    // Sigmoid cell index with clamping outside [-8,8).
    always_comb
    begin
        sig_u = 20'(b_s + 24'sd524288);
        sig_p = PW'(sig_u) * PW'(SIGMOID_ENTRIES);
        if (b_s < -24'sd524288)
            sig_idx = '0;
        else if (b_s >= 24'sd524288)
            sig_idx = IW'(SIGMOID_ENTRIES - 1);
        else
            sig_idx = sig_p[20 +: IW];
    end

    always_comb
    begin
        r_val   = 25'(d_pr >>> 16);
        dw0_new = sat24(64'(e_mw0) + 64'(e_pr0 >>> 16));
        dw1_new = sat24(64'(e_mw1) + 64'(e_pr1 >>> 16));
        f_next  = e_rec;
        case (mode)
            MODE_FWD:
            begin
                f_next.act = e_act;
            end
            MODE_UPD:
            begin
                f_next.v   = e_v;
                f_next.dv  = e_dv;
                f_next.dw0 = dw0_new;
                f_next.dw1 = dw1_new;
                f_next.w0  = sat24(64'(e_rec.w0) - 64'(dw0_new));
                f_next.w1  = sat24(64'(e_rec.w1) - 64'(dw1_new));
            end
            default:
            begin
                f_next = e_rec;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld <= 1'b0;
            b_vld <= 1'b0;
            c_vld <= 1'b0;
            d_vld <= 1'b0;
        end
        else if (shift)
        begin
            a_vld <= vld_in;
            b_vld <= a_vld;
            c_vld <= b_vld;
            d_vld <= c_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            a_rec  <= rec_in;
            a_p0   <= rec_in.w0 * x0;
            a_p1   <= rec_in.w1 * x1;
            a_pt   <= err * rec_in.v;
            a_pdv  <= $signed({1'b0, rates.out_mom}) * rec_in.dv;
            a_pga  <= gain * $signed({1'b0, rec_in.act});
            a_pder <= rec_in.act * (17'd65536 - rec_in.act);
            a_pw0  <= $signed({1'b0, rates.in_mom}) * rec_in.dw0;
            a_pw1  <= $signed({1'b0, rates.in_mom}) * rec_in.dw1;

            b_rec <= a_rec;
            b_s   <= sat24(64'((49'(a_p0) + 49'(a_p1)) >>> 16));
            b_t   <= sat24(64'(a_pt >>> 16));
            b_dv  <= sat24(64'(a_pdv >>> 16) + 64'(a_pga >>> 16));
            b_der <= a_pder[30:16];
            b_mw0 <= 25'(a_pw0 >>> 16);
            b_mw1 <= 25'(a_pw1 >>> 16);

            c_rec <= b_rec;
            c_act <= sig_rom[sig_idx];
            c_ptd <= b_t * $signed({1'b0, b_der});
            c_v   <= sat24(64'(b_rec.v) - 64'(b_dv));
            c_dv  <= b_dv;
            c_mw0 <= b_mw0;
            c_mw1 <= b_mw1;

            d_rec <= c_rec;
            d_pva <= c_rec.v * $signed({1'b0, c_act});
            d_pr  <= 24'(c_ptd >>> 16) * $signed({1'b0, rates.in_rate});
            d_act <= c_act;
            d_v   <= c_v;
            d_dv  <= c_dv;
            d_mw0 <= c_mw0;
            d_mw1 <= c_mw1;

            e_rec <= d_rec;
            e_pr0 <= r_val * x0;
            e_pr1 <= r_val * x1;
            e_act <= d_act;
            e_v   <= d_v;
            e_dv  <= d_dv;
            e_mw0 <= d_mw0;
            e_mw1 <= d_mw1;

            f_rec <= f_next;
        end
    end

    assign rec_out  = f_rec;
    assign prod_vld = d_vld;
    assign prod     = d_pva;

endmodule

// ===== design/mlp_backprop_momentum_trainer.sv =====
// Top level of the two-input sigmoid MLP trainer with momentum backpropagation.
//
//  channel   | signals                          | carries
//  ----------+----------------------------------+------------------------------------
//  s_axis    | tvalid tready tdata[103:0] tuser | one request: operation and operands
//  m_axis    | tvalid tready tdata[47:0]        | one result per request
//  cfg       | valid ready index[1:0] data[15:0]| rate and momentum registers
//
//  Each pass rotates the ring of HIDDEN cells once through the six processing
//  stages, so one unit is handled per cycle per pass. Train makes a forward pass
//  and an update pass, infer a forward pass only, read and write one plain pass.
//  Reset: momenta, weights and activations clear; rates take their defaults.
//  Stalls: a new request is taken while a result still waits on m_axis; a finished
//  request holds in its last step until the output register is free.
module mlp_backprop_momentum_trainer
    import mbt_pkg::*;
#(
    parameter int HIDDEN          = 64,
    parameter int SIGMOID_ENTRIES = 256
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // x0[23:0] x1[47:24] target[71:48] weight_index[79:72] weight_value[103:80]
    input  logic [103:0] s_axis_tdata,
    // operation[1:0]
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // result_value[23:0] error_value[47:24]
    output logic [47:0]  m_axis_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [15:0]  cfg_data
);

    localparam int RING  = HIDDEN + PIPE_DEPTH;
    localparam int SW    = $clog2(RING + 1);
    localparam int ACC_W = 42 + $clog2(HIDDEN + 1);

    state_t state_reg, state_next;

    logic [SW-1:0]      step_reg;
    rates_t             rates_reg;
    op_e_t              op_reg;
    logic signed [23:0] x0_reg, x1_reg, tgt_reg, wv_reg;
    logic [7:0]         unit_reg;
    logic               kbit_reg, is_in_reg, is_out_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [23:0] y_reg, err_reg, gain_reg, rd_reg;
    logic               m_valid_reg;
    logic [47:0]        m_data_reg;

    logic   shift, last_step, in_fire, out_load, hit;
    mode_t  mode;
    unit_t  cell_q [HIDDEN];
    unit_t  pipe_in, pipe_out;
    logic   prod_vld;
    logic signed [41:0] prod;
    logic signed [23:0] res_val, err_val;
    logic [7:0]  in_idx;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign cfg_ready     = 1'b1;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign in_idx        = s_axis_tdata[79:72];
    assign last_step     = (step_reg == SW'(RING - 1));
    assign hit           = (step_reg < SW'(HIDDEN)) && (16'(step_reg) == 16'(unit_reg))
                           && (is_in_reg || is_out_reg);

    // Sequencer: one full ring rotation per pass.
    always_comb
    begin
        state_next = state_reg;
        shift      = 1'b0;
        mode       = MODE_PASS;
        out_load   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (s_axis_tuser == OP_TRAIN || s_axis_tuser == OP_INFER)
                        state_next = ST_FWD;
                    else
                        state_next = ST_PASS;
                end
            end
            ST_FWD:
            begin
                shift = 1'b1;
                mode  = MODE_FWD;
                if (last_step)
                    state_next = ST_YOUT;
            end
            ST_YOUT:
            begin
                state_next = (op_reg == OP_TRAIN) ? ST_ERR : ST_OUT;
            end
            ST_ERR:
            begin
                state_next = ST_GAIN;
            end
            ST_GAIN:
            begin
                state_next = ST_UPD;
            end
            ST_UPD:
            begin
                shift = 1'b1;
                mode  = MODE_UPD;
                if (last_step)
                    state_next = ST_OUT;
            end
            ST_PASS:
            begin
                shift = 1'b1;
                if (last_step)
                    state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!m_valid_reg || m_axis_tready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg  <= '0;
            rates_reg <= '{OUT_MOM_RST, OUT_RATE_RST, IN_MOM_RST, IN_RATE_RST};
        end
        else
        begin
            if (shift)
                step_reg <= last_step ? '0 : step_reg + 1'b1;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_OUT_MOM:  rates_reg.out_mom  <= cfg_data;
                    REG_OUT_RATE: rates_reg.out_rate <= cfg_data;
                    REG_IN_MOM:   rates_reg.in_mom   <= cfg_data;
                    REG_IN_RATE:  rates_reg.in_rate  <= cfg_data;
                    default:      rates_reg          <= rates_reg;
                endcase
            end
        end
    end

    // Latch the request and decode the weight slot.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            op_reg     <= op_e_t'(s_axis_tuser);
            x0_reg     <= s_axis_tdata[23:0];
            x1_reg     <= s_axis_tdata[47:24];
            tgt_reg    <= s_axis_tdata[71:48];
            wv_reg     <= s_axis_tdata[103:80];
            is_in_reg  <= !in_idx[7] && (10'(in_idx) < 10'(2 * HIDDEN));
            is_out_reg <= in_idx[7] && (9'(in_idx[6:0]) < 9'(HIDDEN));
            unit_reg   <= in_idx[7] ? {1'b0, in_idx[6:0]} : {2'b00, in_idx[6:1]};
            kbit_reg   <= in_idx[0];
            acc_reg    <= '0;
            rd_reg     <= '0;
        end
        else
        begin
            if (state_reg == ST_FWD && prod_vld)
                acc_reg <= acc_reg + ACC_W'(prod);
            if (state_reg == ST_PASS && hit)
                rd_reg <= is_out_reg ? cell_q[0].v : (kbit_reg ? cell_q[0].w1 : cell_q[0].w0);
        end
        if (state_reg == ST_YOUT)
            y_reg <= sat24(64'(acc_reg >>> 16));
        if (state_reg == ST_ERR)
            err_reg <= sat24(64'(y_reg) - 64'(tgt_reg));
        if (state_reg == ST_GAIN)
            gain_reg <= 24'((41'($signed({1'b0, rates_reg.out_rate})) * 41'(err_reg)) >>> 16);
    end

    // Head of the ring: apply a weight write as the addressed unit passes.
    always_comb
    begin
        pipe_in = cell_q[0];
        if (state_reg == ST_PASS && op_reg == OP_WRITE && hit)
        begin
            if (is_out_reg)
            begin
                pipe_in.v  = wv_reg;
                pipe_in.dv = '0;
            end
            else if (kbit_reg)
            begin
                pipe_in.w1  = wv_reg;
                pipe_in.dw1 = '0;
            end
            else
            begin
                pipe_in.w0  = wv_reg;
                pipe_in.dw0 = '0;
            end
        end
    end

    // The last cell takes the pipeline output; every other cell takes its neighbour.
    genvar gi;
    generate
        for (gi = 0; gi < HIDDEN; gi++)
        begin : g_cell
            if (gi == HIDDEN - 1)
            begin : g_tail
                mbt_cell u_cell (
                    .clk   (clk),
                    .rst_n (rst_n),
                    .shift (shift),
                    .d     (pipe_out),
                    .q     (cell_q[gi])
                );
            end
            else
            begin : g_body
                mbt_cell u_cell (
                    .clk   (clk),
                    .rst_n (rst_n),
                    .shift (shift),
                    .d     (cell_q[gi + 1]),
                    .q     (cell_q[gi])
                );
            end
        end
    endgenerate

    mbt_pipe #(
        .SIGMOID_ENTRIES (SIGMOID_ENTRIES)
    ) u_pipe (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift    (shift),
        .mode     (mode),
        .vld_in   (step_reg < SW'(HIDDEN)),
        .rec_in   (pipe_in),
        .x0       (x0_reg),
        .x1       (x1_reg),
        .err      (err_reg),
        .gain     (gain_reg),
        .rates    (rates_reg),
        .rec_out  (pipe_out),
        .prod_vld (prod_vld),
        .prod     (prod)
    );

    // Result selection by operation.
    always_comb
    begin
        res_val = '0;
        err_val = '0;
        case (op_reg)
            OP_TRAIN:
            begin
                res_val = y_reg;
                err_val = err_reg;
            end
            OP_INFER: res_val = y_reg;
            OP_READ:  res_val = rd_reg;
            default:  res_val = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if (out_load)
            m_valid_reg <= 1'b1;
        else if (m_axis_tready)
            m_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
            m_data_reg <= {err_val, res_val};
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

endmodule

// ===== design/mbt_checker.sv =====
// Port-level checks for the trainer and their binding to the top level.
module mbt_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata,
    input logic        cfg_ready
);

    // Hold a stalled result steady.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // Drop ready after a transfer: one request at a time.
    a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second request taken while busy");

    // A result appears only as the block returns to idle.
    a_rise_idle: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> s_axis_tready)
        else $error("result issued while still busy");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("configuration port stalled");

endmodule

bind mlp_backprop_momentum_trainer mbt_checker u_mbt_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_ready     (cfg_ready)
);
